[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands for the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define ASSERT_RUN(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// checked on every edge, reset included
`define ASSERT_ALL(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

[rtl/tpl_pkg.sv]
// ---------------------------------------------------------------------------
// tpl_pkg
// shared constants, codes and control types of the timed point lookup
// ---------------------------------------------------------------------------
`default_nettype none

package tpl_pkg;

  localparam int CHANNELS = 4;
  localparam int DEPTH    = 1024;

  localparam int TIME_W   = 48;
  localparam int VAL_W    = 32;
  localparam int FIDX_W   = 10;
  localparam int CH_IN_W  = 4;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = IDX_W + 1;
  localparam int ADDR_W   = (CHANNELS * DEPTH > 2) ? $clog2(CHANNELS * DEPTH) : 1;
  localparam int NUM_W    = TIME_W + CNT_W + 1;
  localparam int STEP_W   = $clog2(IDX_W + 1);

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;
  localparam logic [1:0] ACT_SPARE  = 2'd3;

  localparam logic REG_WINDOW_START  = 1'b0;
  localparam logic REG_WINDOW_LENGTH = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] len;
    logic [VAL_W-1:0]  val;
    logic              vld;
  } entry_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_LAST,
    IDX_QUOT,
    IDX_DEC,
    IDX_INC
  } idx_op_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_ZERO,
    RES_F,
    RES_N
  } res_op_t;

  typedef struct packed {
    logic    take;
    logic    prep;
    logic    mul;
    logic    div;
    idx_op_t idx_op;
    logic    f_take;
    res_op_t res_op;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic in_query;
    logic empty;
    logic le;
    logic ge;
    logic div_last;
    logic idx_zero;
    logic idx_last;
    logic hit;
    logic start_ge;
    logic start_gt;
    logic end_lt;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

[rtl/tpl_ctrl.sv]
// ---------------------------------------------------------------------------
// tpl_ctrl
// sequencer: guess, divide, walk the point table, pick the value
// ---------------------------------------------------------------------------
`default_nettype none

module tpl_ctrl import tpl_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t st,
  output cmd_t         cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_PREP, S_DECIDE, S_MUL, S_DIV, S_QSET,
    S_G_RD, S_G_EV, S_DN_RD, S_DN_EV, S_UP_RD, S_UP_EV,
    S_F_RD, S_F_EV, S_NX, S_N_RD, S_N_EV, S_DONE
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    cmd.idx_op = IDX_HOLD;
    cmd.res_op = RES_NONE;
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (st.in_query) state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (st.empty) begin
          cmd.res_op = RES_ZERO;
          state_next = S_DONE;
        end else if (st.le) begin
          cmd.idx_op = IDX_ZERO;
          state_next = S_G_RD;
        end else if (st.ge) begin
          cmd.idx_op = IDX_LAST;
          state_next = S_G_RD;
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (st.div_last) state_next = S_QSET;
      end
      S_QSET: begin
        cmd.idx_op = IDX_QUOT;
        state_next = S_G_RD;
      end
      S_G_RD:  state_next = S_G_EV;
      S_DN_RD: state_next = S_DN_EV;
      S_UP_RD: state_next = S_UP_EV;
      S_F_RD:  state_next = S_F_EV;
      S_N_RD:  state_next = S_N_EV;
      S_G_EV, S_UP_EV: begin
        if (state == S_G_EV && st.hit) begin
          cmd.f_take = 1'b1;
          state_next = S_NX;
        end else if (state == S_G_EV && st.start_ge) begin
          if (st.idx_zero) begin
            cmd.f_take = 1'b1;
            state_next = S_NX;
          end else begin
            cmd.idx_op = IDX_DEC;
            state_next = S_DN_RD;
          end
        end else if (!st.end_lt) begin
          if (st.start_gt && !st.idx_zero) begin
            cmd.idx_op = IDX_DEC;
            state_next = S_F_RD;
          end else begin
            cmd.f_take = 1'b1;
            state_next = S_NX;
          end
        end else if (st.idx_last) begin
          cmd.f_take = 1'b1;
          state_next = S_NX;
        end else begin
          cmd.idx_op = IDX_INC;
          state_next = S_UP_RD;
        end
      end
      S_DN_EV: begin
        if (st.end_lt || st.idx_zero) begin
          cmd.f_take = 1'b1;
          state_next = S_NX;
        end else begin
          cmd.idx_op = IDX_DEC;
          state_next = S_DN_RD;
        end
      end
      S_F_EV: begin
        cmd.f_take = 1'b1;
        state_next = S_NX;
      end
      S_NX: begin
        if (st.idx_last) begin
          cmd.res_op = RES_F;
          state_next = S_DONE;
        end else begin
          cmd.idx_op = IDX_INC;
          state_next = S_N_RD;
        end
      end
      S_N_EV: begin
        cmd.res_op = RES_N;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[rtl/tpl_dp.sv]
// ---------------------------------------------------------------------------
// tpl_dp
// point memory, counts, window registers, divider and result registers
// ---------------------------------------------------------------------------
`default_nettype none

module tpl_dp import tpl_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [TIME_W-1:0]   cfg_data,
  input  wire logic [1:0]          action,
  input  wire logic [CH_IN_W-1:0]  channel,
  input  wire logic [TIME_W-1:0]   entry_start,
  input  wire logic [TIME_W-1:0]   entry_duration,
  input  wire logic signed [VAL_W-1:0] entry_value,
  input  wire logic                entry_has_value,
  input  wire logic [TIME_W-1:0]   query_time,
  input  wire cmd_t                cmd,
  output status_t                  st,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     found,
  output logic [FIDX_W-1:0]        found_index,
  output logic                     value_ok,
  output logic signed [VAL_W-1:0]  value
);

  logic [TIME_W-1:0]  window_start, window_length;
  logic [CNT_W-1:0]   cnt [CHANNELS];
  entry_t             mem [CHANNELS * DEPTH];
  entry_t             rdata;

  logic [CH_IN_W-1:0] ch_r;
  logic [TIME_W-1:0]  t_r, d_r;
  logic [CNT_W-1:0]   n_r;
  logic               le_r, ge_r, empty_r;
  logic [NUM_W-1:0]   num_r, dv_r;
  logic [IDX_W-1:0]   quot;
  logic [STEP_W-1:0]  step;
  logic [IDX_W-1:0]   idx;

  logic [TIME_W:0]    f_end;
  logic [VAL_W-1:0]   f_val;
  logic               f_vld;
  logic [IDX_W-1:0]   f_idx;

  logic               res_found, res_has;
  logic [IDX_W-1:0]   res_idx;
  logic [VAL_W-1:0]   res_val;

  logic               ch_ok_in, ch_ok_r;
  logic [CNT_W-1:0]   cnt_in, cnt_r;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic [IDX_W-1:0]   nm1;
  logic [TIME_W:0]    rd_end, t49;
  logic [TIME_W-1:0]  d_now;
  logic [NUM_W-1:0]   prod;
  logic               div_bit;

  assign ch_ok_in = {1'b0, channel} < (CH_IN_W + 1)'(CHANNELS);
  assign ch_ok_r  = {1'b0, ch_r} < (CH_IN_W + 1)'(CHANNELS);
  assign cnt_in   = cnt[channel[CH_W-1:0]];
  assign cnt_r    = cnt[ch_r[CH_W-1:0]];
  assign waddr    = ADDR_W'(channel[CH_W-1:0]) * ADDR_W'(DEPTH) + ADDR_W'(cnt_in[IDX_W-1:0]);
  assign raddr    = ADDR_W'(ch_r[CH_W-1:0]) * ADDR_W'(DEPTH) + ADDR_W'(idx);
  assign nm1      = IDX_W'(n_r - CNT_W'(1));
  assign rd_end   = {1'b0, rdata.start} + {1'b0, rdata.len};
  assign t49      = {1'b0, t_r};
  assign d_now    = t_r - window_start;
  assign prod     = NUM_W'(d_r) * NUM_W'(nm1);
  assign div_bit  = num_r >= dv_r;

  always_comb begin
    st          = '0;
    st.in_query = action == ACT_QUERY;
    st.empty    = empty_r;
    st.le       = le_r;
    st.ge       = ge_r;
    st.div_last = step == '0;
    st.idx_zero = idx == '0;
    st.idx_last = idx == nm1;
    st.start_ge = rdata.start >= t_r;
    st.start_gt = rdata.start > t_r;
    st.end_lt   = rd_end < t49;
    st.hit      = st.start_ge && (rd_end <= t49);
    st.out_free = !out_valid || out_ready;
  end

  // config, counts and the point memory
  always_ff @(posedge clk) begin
    if (rst) begin
      window_start  <= '0;
      window_length <= '0;
      for (int i = 0; i < CHANNELS; i++) cnt[i] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW_START:  window_start  <= cfg_data;
          REG_WINDOW_LENGTH: window_length <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.take && ch_ok_in) begin
        if (action == ACT_CLEAR) begin
          cnt[channel[CH_W-1:0]] <= '0;
        end else if (action == ACT_APPEND && cnt_in != CNT_W'(DEPTH)) begin
          cnt[channel[CH_W-1:0]] <= cnt_in + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && ch_ok_in && action == ACT_APPEND && cnt_in != CNT_W'(DEPTH)) begin
      mem[waddr] <= '{start: entry_start, len: entry_duration,
                      val: entry_value, vld: entry_has_value};
    end
    rdata <= mem[raddr];
  end

  // query datapath
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      ch_r <= channel;
      t_r  <= query_time;
    end
    if (cmd.prep) begin
      d_r     <= d_now;
      le_r    <= t_r <= window_start;
      ge_r    <= d_now >= window_length;
      n_r     <= ch_ok_r ? cnt_r : '0;
      empty_r <= (window_length == '0) || !ch_ok_r || (cnt_r == '0);
    end
    if (cmd.mul) begin
      num_r <= prod + NUM_W'(window_length) - NUM_W'(1);
      dv_r  <= NUM_W'(window_length) << (IDX_W - 1);
      quot  <= '0;
      step  <= STEP_W'(IDX_W - 1);
    end
    if (cmd.div) begin
      if (div_bit) num_r <= num_r - dv_r;
      dv_r <= dv_r >> 1;
      quot <= IDX_W'({quot, div_bit});
      step <= step - STEP_W'(1);
    end
    case (cmd.idx_op)
      IDX_ZERO: idx <= '0;
      IDX_LAST: idx <= nm1;
      IDX_QUOT: idx <= quot;
      IDX_DEC:  idx <= idx - IDX_W'(1);
      IDX_INC:  idx <= idx + IDX_W'(1);
      default:  ;
    endcase
    if (cmd.f_take) begin
      f_idx <= idx;
      f_end <= rd_end;
      f_val <= rdata.val;
      f_vld <= rdata.vld;
    end
    case (cmd.res_op)
      RES_ZERO: begin
        res_found <= 1'b0;
        res_idx   <= '0;
        res_has   <= 1'b0;
        res_val   <= '0;
      end
      RES_F: begin
        res_found <= 1'b1;
        res_idx   <= f_idx;
        res_has   <= f_vld;
        res_val   <= f_vld ? f_val : '0;
      end
      RES_N: begin
        res_found <= 1'b1;
        res_idx   <= f_idx;
        if (t49 < f_end || !rdata.vld) begin
          res_has <= f_vld;
          res_val <= f_vld ? f_val : '0;
        end else if (!f_vld || {1'b0, rdata.start} >= f_end) begin
          res_has <= 1'b1;
          res_val <= rdata.val;
        end else begin
          res_has <= 1'b1;
          res_val <= f_val;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      found       <= res_found;
      found_index <= FIDX_W'(res_idx);
      value_ok    <= res_has;
      value       <= res_val;
    end
  end

endmodule

`default_nettype wire

[rtl/timed_point_lookup.sv]
// ---------------------------------------------------------------------------
// timed_point_lookup
// per channel append-only tables of timed points with a guessed-index search
// ---------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_ready    action, channel, entry_*, query_time
//  out      out_valid / out_ready  found, found_index, value_ok, value
//  cfg      cfg_we                 cfg_index, cfg_data
//
//  clear and append are taken in the idle state, which stays ready; a query gives one item
//  query: the window checks, then the restoring divider when the time lies
//  inside the window, then a point read and compare for each step of the walk
//  (one memory read port, registered read data)
//  rst is synchronous; counts and window clear at once, the points need no pass
//  a stalled output holds the next query in its final state
// ---------------------------------------------------------------------------
`default_nettype none

module timed_point_lookup import tpl_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic                    cfg_index,
  input  wire logic [TIME_W-1:0]       cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [1:0]              action,
  input  wire logic [CH_IN_W-1:0]      channel,
  input  wire logic [TIME_W-1:0]       entry_start,
  input  wire logic [TIME_W-1:0]       entry_duration,
  input  wire logic signed [VAL_W-1:0] entry_value,
  input  wire logic                    entry_has_value,
  input  wire logic [TIME_W-1:0]       query_time,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         found,
  output logic [FIDX_W-1:0]            found_index,
  output logic                         value_ok,
  output logic signed [VAL_W-1:0]      value
);

  cmd_t    cmd;
  status_t st;

  tpl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  tpl_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .action          (action),
    .channel         (channel),
    .entry_start     (entry_start),
    .entry_duration  (entry_duration),
    .entry_value     (entry_value),
    .entry_has_value (entry_has_value),
    .query_time      (query_time),
    .cmd             (cmd),
    .st              (st),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .found           (found),
    .found_index     (found_index),
    .value_ok        (value_ok),
    .value           (value)
  );

endmodule

`default_nettype wire

[rtl/tpl_checker.sv]
// ---------------------------------------------------------------------------
// tpl_checker
// port level checks of the timed point lookup, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tpl_checker import tpl_pkg::*; (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic [1:0]              action,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic                    found,
  input wire logic [FIDX_W-1:0]       found_index,
  input wire logic                    value_ok,
  input wire logic signed [VAL_W-1:0] value
);

  `ASSERT_ALL(a_reset_empty, clk, rst |=> !out_valid)
  `ASSERT_RUN(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(value))
  `ASSERT_RUN(a_miss_zero, clk, rst, out_valid && !found |-> found_index == '0 && !value_ok)
  `ASSERT_RUN(a_no_value_zero, clk, rst, out_valid && !value_ok |-> value == '0)
  `ASSERT_RUN(a_short_action, clk, rst, in_valid && in_ready && action != ACT_QUERY |=> in_ready)

endmodule

bind timed_point_lookup tpl_checker u_tpl_checker (.*);

`default_nettype wire
